// ===== rtl/doubly_linked_list_manager_unit_assert.svh =====
// Assertion macros used by the list manager controller.
`ifndef DOUBLY_LINKED_LIST_MANAGER_UNIT_ASSERT_SVH
`define DOUBLY_LINKED_LIST_MANAGER_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DLLM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DLLM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dllm_pkg.sv =====
package dllm_pkg;

    // Field widths
    localparam int FUNC_W      = 3;
    localparam int INDEX_W     = 8;
    localparam int LINK_W      = INDEX_W + 1;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Default pool size
    localparam int NODE_COUNT_DEF = 256;
    localparam int POOL_MAX       = 1 << INDEX_W;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT_HEAD   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT_TAIL   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INSERT_AFTER  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_INSERT_BEFORE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_UNLINK        = 3'd4;

    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [LINK_W-1:0]  link_t;

    // Null link: valid bit clear
    localparam link_t LINK_NULL = '0;

    // Decoded operation
    typedef enum logic [2:0] {
        OP_NONE,
        OP_HEAD,
        OP_TAIL,
        OP_AFTER,
        OP_BEFORE,
        OP_UNLINK
    } op_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LINK,
        ST_FIX,
        ST_HOLD
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic link;
        logic fix;
        logic load_out;
    } cmd_t;

endpackage

// ===== rtl/doubly_linked_list_manager_unit.sv =====
// A request passes through the link and fix states before its result is loaded;
// the load waits in the hold state if the previous result has not been taken.
// No new request is taken until the current one is done; each request reads the
// link tables once and then writes them over their single write ports in the link and fix states.
// Reset: synchronous, active low; head and tail go null, the link tables are not
// cleared and need no clearing pass.
module doubly_linked_list_manager_unit #(
    parameter int NODE_COUNT = dllm_pkg::NODE_COUNT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // func[2:0], node_index[10:3], anchor_index[18:11], anchor_present[19]
    input  logic [dllm_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // head_index[7:0], head_valid[8], tail_index[16:9], tail_valid[17]
    output logic [dllm_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import dllm_pkg::*;

    cmd_t   cmd;
    index_t head_index;
    logic   head_valid;
    index_t tail_index;
    logic   tail_valid;

    dllm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dllm_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .in_func           (s_tdata[FUNC_W-1:0]),
        .in_node_index     (s_tdata[FUNC_W+INDEX_W-1:FUNC_W]),
        .in_anchor_index   (s_tdata[FUNC_W+2*INDEX_W-1:FUNC_W+INDEX_W]),
        .in_anchor_present (s_tdata[FUNC_W+2*INDEX_W]),
        .out_head_index    (head_index),
        .out_head_valid    (head_valid),
        .out_tail_index    (tail_index),
        .out_tail_valid    (tail_valid)
    );

    // Pack the result, zero fill to whole bytes
    assign m_tdata = {{(OUT_TDATA_W - 2*INDEX_W - 2){1'b0}},
                      tail_valid, tail_index, head_valid, head_index};

endmodule

// ===== rtl/dllm_ctrl.sv =====
module dllm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output dllm_pkg::cmd_t cmd
);
    import dllm_pkg::*;

`include "doubly_linked_list_manager_unit_assert.svh"

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // State and result-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LINK;
                end
            end
            ST_LINK: begin
                cmd.link   = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.fix = 1'b1;
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Fill on load, drop on transfer
    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    `DLLM_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, cmd.accept,
        !s_tready ##1 !s_tready, "input taken while a request is in flight")
    `DLLM_ASSERT_SAME(a_result_per_item, aclk, aresetn, cmd.accept,
        ##2 (cmd.load_out || state_next == ST_HOLD), "request finished without a result")
    `DLLM_ASSERT_SAME(a_hold_means_full, aclk, aresetn, state_reg == ST_HOLD,
        out_valid_reg, "waiting on a free result register")

endmodule

// ===== rtl/dllm_datapath.sv =====
module dllm_datapath #(
    parameter int NODE_COUNT = dllm_pkg::NODE_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dllm_pkg::cmd_t              cmd,
    input  logic [dllm_pkg::FUNC_W-1:0] in_func,
    input  dllm_pkg::index_t            in_node_index,
    input  dllm_pkg::index_t            in_anchor_index,
    input  logic                        in_anchor_present,
    output dllm_pkg::index_t            out_head_index,
    output logic                        out_head_valid,
    output dllm_pkg::index_t            out_tail_index,
    output logic                        out_tail_valid
);
    import dllm_pkg::*;

    localparam int DEPTH = (NODE_COUNT < POOL_MAX) ? NODE_COUNT : POOL_MAX;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic in_pool(input index_t idx);
        return 32'(idx) < NODE_COUNT;
    endfunction

    function automatic logic is_node(input link_t link);
        return link[LINK_W-1] && in_pool(link[INDEX_W-1:0]);
    endfunction

    function automatic logic [AW-1:0] addr_of(input index_t idx);
        return idx[AW-1:0];
    endfunction

    // Link tables
    link_t next_mem [DEPTH];
    link_t prev_mem [DEPTH];

    op_t    op_reg;
    index_t node_reg;
    index_t anch_reg;
    link_t  rd_next_reg;
    link_t  rd_prev_reg;
    link_t  head_reg;
    link_t  head_next;
    link_t  tail_reg;
    link_t  tail_next;
    index_t out_head_reg;
    logic   out_head_valid_reg;
    index_t out_tail_reg;
    logic   out_tail_valid_reg;

    op_t           op_dec;
    logic [AW-1:0] next_raddr;
    logic [AW-1:0] prev_raddr;
    logic          next_we;
    logic [AW-1:0] next_waddr;
    link_t         next_wdata;
    logic          prev_we;
    logic [AW-1:0] prev_waddr;
    link_t         prev_wdata;
    link_t         me;
    link_t         anch_link;

    // Decode the incoming request
    always_comb begin
        op_dec = OP_NONE;
        if (in_pool(in_node_index)) begin
            case (in_func)
                FUNC_INSERT_HEAD:  op_dec = OP_HEAD;
                FUNC_INSERT_TAIL:  op_dec = OP_TAIL;
                FUNC_INSERT_AFTER: begin
                    if (!in_anchor_present) begin
                        op_dec = OP_HEAD;
                    end else if (in_pool(in_anchor_index)) begin
                        op_dec = OP_AFTER;
                    end
                end
                FUNC_INSERT_BEFORE: begin
                    if (!in_anchor_present) begin
                        op_dec = OP_TAIL;
                    end else if (in_pool(in_anchor_index)) begin
                        op_dec = OP_BEFORE;
                    end
                end
                FUNC_UNLINK:       op_dec = OP_UNLINK;
                default:           op_dec = OP_NONE;
            endcase
        end
    end

    // Unlink reads both links of the node, anchored inserts read the anchor and use one of its links
    assign next_raddr = (op_dec == OP_UNLINK) ? addr_of(in_node_index)
                                              : addr_of(in_anchor_index);
    assign prev_raddr = next_raddr;

    // Latch the request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= OP_NONE;
        end else if (cmd.accept) begin
            op_reg <= op_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            node_reg <= in_node_index;
            anch_reg <= in_anchor_index;
        end
    end

    // Next-link table: one write, one registered read
    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (cmd.accept) begin
            rd_next_reg <= next_mem[next_raddr];
        end
    end

    // Prev-link table: one write, one registered read
    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (cmd.accept) begin
            rd_prev_reg <= prev_mem[prev_raddr];
        end
    end

    assign me        = {1'b1, node_reg};
    assign anch_link = {1'b1, anch_reg};

    // Table writes for the two update phases
    always_comb begin
        next_we    = 1'b0;
        next_waddr = addr_of(node_reg);
        next_wdata = LINK_NULL;
        prev_we    = 1'b0;
        prev_waddr = addr_of(node_reg);
        prev_wdata = LINK_NULL;
        if (cmd.link) begin
            case (op_reg)
                OP_HEAD: begin
                    next_we    = 1'b1;
                    next_wdata = head_reg;
                    prev_we    = 1'b1;
                end
                OP_TAIL: begin
                    prev_we    = 1'b1;
                    prev_wdata = tail_reg;
                    next_we    = 1'b1;
                end
                OP_AFTER: begin
                    prev_we    = is_node(rd_next_reg);
                    prev_waddr = addr_of(rd_next_reg[INDEX_W-1:0]);
                    prev_wdata = me;
                    next_we    = 1'b1;
                    next_wdata = rd_next_reg;
                end
                OP_BEFORE: begin
                    next_we    = is_node(rd_prev_reg);
                    next_waddr = addr_of(rd_prev_reg[INDEX_W-1:0]);
                    next_wdata = me;
                    prev_we    = 1'b1;
                    prev_wdata = rd_prev_reg;
                end
                OP_UNLINK: begin
                    next_we    = is_node(rd_prev_reg);
                    next_waddr = addr_of(rd_prev_reg[INDEX_W-1:0]);
                    next_wdata = rd_next_reg;
                    prev_we    = is_node(rd_next_reg);
                    prev_waddr = addr_of(rd_next_reg[INDEX_W-1:0]);
                    prev_wdata = rd_prev_reg;
                end
                default: ;
            endcase
        end else if (cmd.fix) begin
            case (op_reg)
                OP_HEAD: begin
                    prev_we    = is_node(head_reg);
                    prev_waddr = addr_of(head_reg[INDEX_W-1:0]);
                    prev_wdata = me;
                end
                OP_TAIL: begin
                    next_we    = is_node(tail_reg);
                    next_waddr = addr_of(tail_reg[INDEX_W-1:0]);
                    next_wdata = me;
                end
                OP_AFTER: begin
                    prev_we    = 1'b1;
                    prev_wdata = anch_link;
                    next_we    = 1'b1;
                    next_waddr = addr_of(anch_reg);
                    next_wdata = me;
                end
                OP_BEFORE: begin
                    next_we    = 1'b1;
                    next_wdata = anch_link;
                    prev_we    = 1'b1;
                    prev_waddr = addr_of(anch_reg);
                    prev_wdata = me;
                end
                default: ;
            endcase
        end
    end

    // Head and tail after the request
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (cmd.fix) begin
            case (op_reg)
                OP_HEAD: begin
                    head_next = me;
                    if (!is_node(head_reg)) tail_next = me;
                end
                OP_TAIL: begin
                    tail_next = me;
                    if (!is_node(tail_reg)) head_next = me;
                end
                OP_AFTER: begin
                    if (!is_node(rd_next_reg)) tail_next = me;
                end
                OP_BEFORE: begin
                    if (!is_node(rd_prev_reg)) head_next = me;
                end
                OP_UNLINK: begin
                    if (!is_node(rd_prev_reg)) head_next = rd_next_reg;
                    if (!is_node(rd_next_reg)) tail_next = rd_prev_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= LINK_NULL;
            tail_reg <= LINK_NULL;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_head_valid_reg <= is_node(head_next);
            out_head_reg       <= is_node(head_next) ? head_next[INDEX_W-1:0] : '0;
            out_tail_valid_reg <= is_node(tail_next);
            out_tail_reg       <= is_node(tail_next) ? tail_next[INDEX_W-1:0] : '0;
        end
    end

    assign out_head_index = out_head_reg;
    assign out_head_valid = out_head_valid_reg;
    assign out_tail_index = out_tail_reg;
    assign out_tail_valid = out_tail_valid_reg;

endmodule

// ===== tb/sv/doubly_linked_list_manager_unit_test.sv =====
module doubly_linked_list_manager_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dllm_pkg::*;

    localparam int NODES       = NODE_COUNT_DEF;
    localparam int WF_ITEMS    = 1450;
    localparam int MISUSE_ITEMS = 200;
    localparam int STALL_LIMIT = 2000;

    // Function codes the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    // One result transfer, highest field first
    typedef struct packed {
        logic   tail_valid;
        index_t tail_index;
        logic   head_valid;
        index_t head_index;
    } list_ends_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // func[2:0], node_index[10:3], anchor_index[18:11], anchor_present[19]
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // head_index[7:0], head_valid[8], tail_index[16:9], tail_valid[17]
    logic [OUT_TDATA_W-1:0] m_tdata;

    doubly_linked_list_manager_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Requests waiting for the driver, and head/tail reports still owed
    logic [IN_TDATA_W-1:0] pending_req_q[$];
    list_ends_t            ends_expected_q[$];

    // Predicted list: link tables and end pointers
    link_t next_tbl [NODES];
    link_t prev_tbl [NODES];
    link_t head_lnk = LINK_NULL;
    link_t tail_lnk = LINK_NULL;

    // Stimulus-side view of the list while it is kept well formed
    index_t order_q[$];
    bit     linked [NODES];
    bit     written [NODES];
    index_t written_q[$];

    int unsigned fail_count   = 0;
    int unsigned wf_count     = 0;
    int unsigned quiet_cycles = 0;
    bit          idle_off     = 1'b0;

    int unsigned src_gap = 0, src_mode_left = 0, src_idle_pct = 0;
    int unsigned sink_gap = 0, sink_mode_left = 0, sink_idle_pct = 0;
    list_ends_t  want, got;

    // ---------------------------------------------------------------- predictor

    function automatic void link_at_head(index_t n);
        link_t self;
        self = {1'b1, n};
        next_tbl[n] = head_lnk;
        prev_tbl[n] = LINK_NULL;
        if (head_lnk[INDEX_W]) prev_tbl[head_lnk[INDEX_W-1:0]] = self;
        else tail_lnk = self;
        head_lnk = self;
    endfunction

    function automatic void link_at_tail(index_t n);
        link_t self;
        self = {1'b1, n};
        next_tbl[n] = LINK_NULL;
        prev_tbl[n] = tail_lnk;
        if (tail_lnk[INDEX_W]) next_tbl[tail_lnk[INDEX_W-1:0]] = self;
        else head_lnk = self;
        tail_lnk = self;
    endfunction

    // Steps run in a fixed order so that misuse (node equal to anchor) resolves the same way
    function automatic void link_after(index_t a, index_t n);
        link_t self, follower;
        self     = {1'b1, n};
        follower = next_tbl[a];
        if (follower[INDEX_W]) prev_tbl[follower[INDEX_W-1:0]] = self;
        else tail_lnk = self;
        prev_tbl[n] = {1'b1, a};
        next_tbl[n] = next_tbl[a];
        next_tbl[a] = self;
    endfunction

    function automatic void link_before(index_t b, index_t n);
        link_t self, leader;
        self   = {1'b1, n};
        leader = prev_tbl[b];
        if (leader[INDEX_W]) next_tbl[leader[INDEX_W-1:0]] = self;
        else head_lnk = self;
        next_tbl[n] = {1'b1, b};
        prev_tbl[n] = prev_tbl[b];
        prev_tbl[b] = self;
    endfunction

    function automatic void unlink_node(index_t n);
        link_t p, q;
        p = prev_tbl[n];
        q = next_tbl[n];
        if (p[INDEX_W]) next_tbl[p[INDEX_W-1:0]] = q;
        else head_lnk = q;
        if (q[INDEX_W]) prev_tbl[q[INDEX_W-1:0]] = p;
        else tail_lnk = p;
    endfunction

    // Apply one accepted request and queue the head/tail it must report.
    // Every 8-bit index lies inside the 256-node pool, so no request is dropped for range.
    function automatic void apply_list_request(logic [IN_TDATA_W-1:0] word);
        logic [FUNC_W-1:0] f;
        index_t            n, a;
        logic              has_a;
        list_ends_t        r;
        f     = word[2:0];
        n     = word[10:3];
        a     = word[18:11];
        has_a = word[19];
        case (f)
            FUNC_INSERT_HEAD:   link_at_head(n);
            FUNC_INSERT_TAIL:   link_at_tail(n);
            FUNC_INSERT_AFTER:  if (!has_a) link_at_head(n); else link_after(a, n);
            FUNC_INSERT_BEFORE: if (!has_a) link_at_tail(n); else link_before(a, n);
            FUNC_UNLINK:        unlink_node(n);
            default: ;
        endcase
        r.head_valid = head_lnk[INDEX_W];
        r.head_index = head_lnk[INDEX_W] ? head_lnk[INDEX_W-1:0] : '0;
        r.tail_valid = tail_lnk[INDEX_W];
        r.tail_index = tail_lnk[INDEX_W] ? tail_lnk[INDEX_W-1:0] : '0;
        ends_expected_q.push_back(r);
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void send_req(logic [FUNC_W-1:0] f, index_t n, index_t a, logic has_a);
        pending_req_q.push_back({4'b0000, has_a, a, n, f});
        // every insert writes both links of the node, so it may be read later
        if ((f == FUNC_INSERT_HEAD || f == FUNC_INSERT_TAIL || f == FUNC_INSERT_AFTER ||
             f == FUNC_INSERT_BEFORE) && !written[n]) begin
            written[n] = 1'b1;
            written_q.push_back(n);
        end
    endfunction

    // Insert n into a consistent list and track where it lands
    function automatic void plan_insert(logic [FUNC_W-1:0] f, index_t n, index_t a, logic has_a);
        int unsigned pos;
        pos = 0;
        send_req(f, n, a, has_a);
        linked[n] = 1'b1;
        foreach (order_q[i]) if (order_q[i] == a) pos = i;
        if (f == FUNC_INSERT_HEAD || (f == FUNC_INSERT_AFTER && !has_a)) order_q.push_front(n);
        else if (f == FUNC_INSERT_TAIL || (f == FUNC_INSERT_BEFORE && !has_a))
            order_q.push_back(n);
        else if (f == FUNC_INSERT_AFTER) order_q.insert(pos + 1, n);
        else order_q.insert(pos, n);
    endfunction

    function automatic void plan_unlink(index_t n);
        int unsigned pos;
        pos = 0;
        send_req(FUNC_UNLINK, n, index_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        foreach (order_q[i]) if (order_q[i] == n) pos = i;
        order_q.delete(pos);
        linked[n] = 1'b0;
    endfunction

    // Position in the list, leaning toward the two ends
    function automatic int unsigned pick_pos();
        int unsigned sz;
        sz = order_q.size();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return sz - 1;
            default: return $urandom_range(0, sz - 1);
        endcase
    endfunction

    function automatic index_t pick_free();
        index_t n;
        if ($urandom_range(0, 15) == 0 && !linked[0]) return 8'h00;
        if ($urandom_range(0, 15) == 0 && !linked[NODES-1]) return 8'hFF;
        do n = index_t'($urandom_range(0, NODES - 1)); while (linked[n]);
        return n;
    endfunction

    // One well-formed request, or now and then an unused code
    function automatic void plan_step(int unsigned unlink_pct);
        int unsigned sz;
        index_t      n, junk;
        sz   = order_q.size();
        junk = index_t'($urandom_range(0, 255));
        if ($urandom_range(0, 19) == 0) begin
            send_req(FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)),
                     index_t'($urandom_range(0, 255)), junk, 1'($urandom_range(0, 1)));
            return;
        end
        wf_count++;
        if (sz != 0 && (sz == NODES || $urandom_range(0, 99) < unlink_pct)) begin
            plan_unlink(order_q[pick_pos()]);
            return;
        end
        n = pick_free();
        case ($urandom_range(0, 5))
            0: plan_insert(FUNC_INSERT_HEAD, n, junk, 1'($urandom_range(0, 1)));
            1: plan_insert(FUNC_INSERT_TAIL, n, junk, 1'($urandom_range(0, 1)));
            2: if (sz == 0) plan_insert(FUNC_INSERT_AFTER, n, junk, 1'b0);
               else plan_insert(FUNC_INSERT_AFTER, n, order_q[pick_pos()], 1'b1);
            3: if (sz == 0) plan_insert(FUNC_INSERT_BEFORE, n, junk, 1'b0);
               else plan_insert(FUNC_INSERT_BEFORE, n, order_q[pick_pos()], 1'b1);
            4: plan_insert(FUNC_INSERT_AFTER, n, junk, 1'b0);
            default: plan_insert(FUNC_INSERT_BEFORE, n, junk, 1'b0);
        endcase
    endfunction

    // Grow toward a peak size, then drain back to an empty list
    function automatic void plan_session(int unsigned peak);
        int unsigned grow_unlink, drain_unlink;
        grow_unlink  = (peak == NODES) ? 5 : 25;
        drain_unlink = (peak == NODES) ? 95 : 75;
        while (order_q.size() < peak && wf_count < WF_ITEMS) plan_step(grow_unlink);
        while (order_q.size() != 0) plan_step(drain_unlink);
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 4;
            2:       return 15;
            default: return 40;
        endcase
    endfunction

    function automatic bit list_busy();
        return pending_req_q.size() != 0 || s_tvalid || ends_expected_q.size() != 0;
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            // predict on every accepted request
            if (s_tvalid && s_tready) apply_list_request(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (src_mode_left == 0) begin
                    src_mode_left = $urandom_range(20, 300);
                    src_idle_pct  = pick_idle_pct();
                end
                src_mode_left--;
                if (!idle_off && src_gap != 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (!idle_off && $urandom_range(0, 99) < src_idle_pct) begin
                    src_gap = $urandom_range(0, 18);
                    s_tvalid <= 1'b0;
                end else if (pending_req_q.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_req_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            // compare each result transfer with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(list_ends_t)-1:0];
                if (ends_expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count++;
                end else begin
                    want = ends_expected_q.pop_front();
                    if (got.head_index !== want.head_index) begin
                        $display("%0t: head_index expected %0d actual %0d",
                                 $time, want.head_index, got.head_index);
                        fail_count++;
                    end
                    if (got.head_valid !== want.head_valid) begin
                        $display("%0t: head_valid expected %0d actual %0d",
                                 $time, want.head_valid, got.head_valid);
                        fail_count++;
                    end
                    if (got.tail_index !== want.tail_index) begin
                        $display("%0t: tail_index expected %0d actual %0d",
                                 $time, want.tail_index, got.tail_index);
                        fail_count++;
                    end
                    if (got.tail_valid !== want.tail_valid) begin
                        $display("%0t: tail_valid expected %0d actual %0d",
                                 $time, want.tail_valid, got.tail_valid);
                        fail_count++;
                    end
                end
            end
            // back-pressure in random bursts
            if (sink_mode_left == 0) begin
                sink_mode_left = $urandom_range(20, 300);
                sink_idle_pct  = pick_idle_pct();
            end
            sink_mode_left--;
            if (!idle_off && sink_gap != 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 99) < sink_idle_pct) begin
                sink_gap = $urandom_range(0, 18);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("doubly_linked_list_manager_unit_test failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        logic [FUNC_W-1:0] f;
        index_t            n, a;
        logic              has_a;
        int unsigned       peak;
        bit                full_done;
        full_done = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty list, null anchors, both ends, middle, unused codes
        send_req(FUNC_SPARE_HI, 8'hFF, 8'hFF, 1'b1);
        plan_insert(FUNC_INSERT_AFTER, 8'h00, 8'hFF, 1'b0);
        plan_unlink(8'h00);
        plan_insert(FUNC_INSERT_BEFORE, 8'hFF, 8'hAA, 1'b0);
        plan_insert(FUNC_INSERT_HEAD, 8'h00, 8'h55, 1'b1);
        plan_insert(FUNC_INSERT_TAIL, 8'h80, 8'h00, 1'b0);
        plan_insert(FUNC_INSERT_AFTER, 8'h01, 8'h80, 1'b1);
        plan_insert(FUNC_INSERT_BEFORE, 8'hFE, 8'h00, 1'b1);
        plan_insert(FUNC_INSERT_AFTER, 8'h55, 8'h00, 1'b1);
        plan_insert(FUNC_INSERT_BEFORE, 8'hAA, 8'hFF, 1'b1);
        send_req(FUNC_SPARE_LO, 8'h00, 8'h00, 1'b0);
        plan_insert(FUNC_INSERT_AFTER, 8'h02, 8'h7F, 1'b0);
        plan_insert(FUNC_INSERT_BEFORE, 8'h03, 8'h80, 1'b0);
        plan_unlink(8'h02);
        plan_unlink(8'h03);
        plan_unlink(8'h55);
        plan_unlink(8'hAA);
        plan_unlink(8'h01);
        plan_unlink(8'hFE);
        plan_unlink(8'hFF);
        plan_unlink(8'h00);
        plan_unlink(8'h80);

        // hold off until every report is in
        while (list_busy()) @(posedge aclk);

        // Random well-formed sessions, one of them filling the whole pool
        while (wf_count < WF_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: peak = $urandom_range(1, 6);
                6, 7:             peak = $urandom_range(7, 40);
                8:                peak = $urandom_range(41, 120);
                default:          peak = 1;
            endcase
            if (!full_done && wf_count > WF_ITEMS / 3) begin
                peak      = NODES;
                full_done = 1'b1;
            end
            plan_session(peak);
        end

        while (list_busy()) @(posedge aclk);
        idle_off = 1'b1;

        // Misuse: relinking linked nodes, anchors off the list, unlinking twice.
        // Anchors and unlinked nodes are drawn only from nodes written before.
        repeat (MISUSE_ITEMS) begin
            f     = FUNC_W'($urandom_range(FUNC_INSERT_HEAD, FUNC_SPARE_HI));
            has_a = 1'($urandom_range(0, 1));
            a     = index_t'($urandom_range(0, 255));
            n     = $urandom_range(0, 1) ? written_q[$urandom_range(0, written_q.size() - 1)]
                                         : index_t'($urandom_range(0, 255));
            if (f == FUNC_UNLINK)
                n = written_q[$urandom_range(0, written_q.size() - 1)];
            if ((f == FUNC_INSERT_AFTER || f == FUNC_INSERT_BEFORE) && has_a)
                a = written_q[$urandom_range(0, written_q.size() - 1)];
            send_req(f, n, a, has_a);
        end

        // drain, then give the block time to show any stray result
        while (list_busy()) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("doubly_linked_list_manager_unit_test passed");
        end else begin
            $display("doubly_linked_list_manager_unit_test failed");
        end
        $finish;
    end

endmodule
